// ===== rtl/peak_pyramid_builder_top_assert.svh =====
// Assertion macros shared by the peak pyramid builder RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PEAK_PYRAMID_BUILDER_TOP_ASSERT_SVH
`define PEAK_PYRAMID_BUILDER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// check gated off while reset is asserted
`define PPB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// check that also holds across reset
`define PPB_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define PPB_ASSERT(lbl, clk, rst_n, prop)
`define PPB_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// ===== rtl/ppb_pkg.sv =====
// Package for the peak pyramid builder: payload structs, field widths,
// default sizes and the peak scaling helpers. No dependencies.
package ppb_pkg;

    localparam int LEVEL0_ENTRIES_DEF = 1024;
    localparam int NUM_LEVELS_DEF     = 4;
    localparam int MAX_WINDOW_DEF     = 16;

    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 8;
    localparam int LEVEL_W  = 2;
    localparam int POS_W    = 10;
    localparam int WLEN_W   = 5;

    localparam logic [WLEN_W-1:0] WINDOW_RESET = WLEN_W'(16);
    localparam logic [PEAK_W-1:0] PEAK_SAT     = '1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_high;
        logic signed [SAMPLE_W-1:0] sample_low;
        logic                       end_of_block;
    } t_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   position;
        logic [PEAK_W-1:0]  peak_max;
        logic [PEAK_W-1:0]  peak_min;
    } t_entry;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   position;
        logic [PEAK_W-1:0]  peak_max;
        logic [PEAK_W-1:0]  peak_min;
        logic               last;
    } t_out;

    // running max is never negative: /128 is bits 14:7, never above 255
    function automatic logic [PEAK_W-1:0] scale_max(input logic signed [SAMPLE_W-1:0] hi);
        return hi[14:7];
    endfunction

    // running min is never positive: negate, /128, saturate (-32768 gives 256)
    function automatic logic [PEAK_W-1:0] scale_min(input logic signed [SAMPLE_W-1:0] lo);
        logic [SAMPLE_W:0] neg;
        neg = (SAMPLE_W+1)'(0) - {lo[SAMPLE_W-1], lo};
        return neg[SAMPLE_W-1] ? PEAK_SAT : neg[SAMPLE_W-2:7];
    endfunction

    function automatic logic [PEAK_W-1:0] peak_umax(input logic [PEAK_W-1:0] a,
                                                   input logic [PEAK_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/peak_pyramid_builder_top.sv =====
// Top level of the peak pyramid builder: ports, window length register,
// input register. Uses ppb_pkg, ppb_core and ppb_out_buf.
//
// Min/max peak pyramid builder. Each input beat carries a signed 16-bit
// high/low sample pair; pairs are folded into a running max/min over
// window_length beats (clamped to 1..MAX_WINDOW; both values start at 0).
// When a window closes, or on a beat flagged end_of_block, a level-0 entry
// with max/128 and -min/128 (saturated to 255) is produced, and each coarser
// level emits the element-wise max of two entries of the level below. End of
// block flushes a short window and any unpaired entries (paired with zero)
// and restarts all positions. An input beat yields 0 to NUM_LEVELS output
// beats, lowest level first, with last set on the final one.
// Throughput: an input beat is taken every cycle as long as the beat in the
// input register produces no results or the result buffer is free; a beat
// that produces results occupies the buffer until all are sent, since the
// output moves one entry per cycle while i_ready is high. An accepted beat
// passes the input register, then the result buffer, on its way out. The
// user must write window_length (i_cfg_we/i_cfg_data) only while the block
// is idle; the block does not enforce this. Reset value is 16.

module peak_pyramid_builder_top import ppb_pkg::*; #(
    parameter int LEVEL0_ENTRIES = LEVEL0_ENTRIES_DEF,
    parameter int NUM_LEVELS     = NUM_LEVELS_DEF,
    parameter int MAX_WINDOW     = MAX_WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_ready,
    input  t_in               i_data,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output t_out              o_data,
    // window_length register
    input  logic              i_cfg_we,
    input  logic [WLEN_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(NUM_LEVELS + 1);

    logic [WLEN_W-1:0]       r_window_length;
    logic                    r_in_valid, n_in_valid;
    t_in                     r_in;

    t_entry [NUM_LEVELS-1:0] core_ent;
    logic [CNT_W-1:0]        core_cnt;
    logic                    core_fire;
    logic                    buf_free;
    logic                    buf_load;

    // The held beat goes through the core when it has no results to deliver
    // or the buffer can take its whole set this cycle.
    always_comb begin
        core_fire  = r_in_valid && ((core_cnt == '0) || buf_free);
        buf_load   = core_fire && (core_cnt != '0);
        o_ready    = !r_in_valid || core_fire;
        n_in_valid = (i_valid && o_ready) || (r_in_valid && !core_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_RESET;
            r_in_valid      <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_window_length <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
    end

    ppb_core #(
        .LEVEL0_ENTRIES (LEVEL0_ENTRIES),
        .NUM_LEVELS     (NUM_LEVELS),
        .MAX_WINDOW     (MAX_WINDOW),
        .CNT_W          (CNT_W)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_window_length (r_window_length),
        .i_in            (r_in),
        .i_fire          (core_fire),
        .o_ent           (core_ent),
        .o_cnt           (core_cnt)
    );

    ppb_out_buf #(
        .NUM_LEVELS (NUM_LEVELS),
        .CNT_W      (CNT_W)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (buf_load),
        .i_cnt   (core_cnt),
        .i_ent   (core_ent),
        .o_free  (buf_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// ===== rtl/ppb_core.sv =====
// Window reduction and level cascade: holds all pyramid state and forms the
// result set of one item. Depends on ppb_pkg and the assertion header.
`include "peak_pyramid_builder_top_assert.svh"

module ppb_core import ppb_pkg::*; #(
    parameter int LEVEL0_ENTRIES = LEVEL0_ENTRIES_DEF,
    parameter int NUM_LEVELS     = NUM_LEVELS_DEF,
    parameter int MAX_WINDOW     = MAX_WINDOW_DEF,
    parameter int CNT_W          = $clog2(NUM_LEVELS + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [WLEN_W-1:0]       i_window_length,
    input  t_in                     i_in,
    input  logic                    i_fire,
    output t_entry [NUM_LEVELS-1:0] o_ent,
    output logic [CNT_W-1:0]        o_cnt
);

    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int PCNT_W = $clog2(LEVEL0_ENTRIES);
    localparam int NH     = NUM_LEVELS - 1;

    logic signed [SAMPLE_W-1:0] r_win_high, n_win_high;
    logic signed [SAMPLE_W-1:0] r_win_low,  n_win_low;
    logic [LEN_W-1:0]           r_fill,     n_fill;
    logic [PCNT_W-1:0]          r_pos      [NUM_LEVELS];
    logic [PCNT_W-1:0]          n_pos      [NUM_LEVELS];
    logic [PEAK_W-1:0]          r_held_max [NH];
    logic [PEAK_W-1:0]          n_held_max [NH];
    logic [PEAK_W-1:0]          r_held_min [NH];
    logic [PEAK_W-1:0]          n_held_min [NH];
    logic [NH-1:0]              r_held_valid, n_held_valid;

    logic [LEN_W-1:0]           len;
    logic [LEN_W:0]             fill_inc;
    logic signed [SAMPLE_W-1:0] upd_high, upd_low;
    logic                       close;
    logic                       eob;
    logic [NUM_LEVELS-1:0]      em;
    logic [NUM_LEVELS-1:0]      carry;
    logic [PEAK_W-1:0]          cmax [NUM_LEVELS];
    logic [PEAK_W-1:0]          cmin [NUM_LEVELS];

    // window update; out-of-range lengths clamp to 1..MAX_WINDOW
    always_comb begin
        if (i_window_length == '0) begin
            len = LEN_W'(1);
        end else if (int'(i_window_length) > MAX_WINDOW) begin
            len = LEN_W'(MAX_WINDOW);
        end else begin
            len = LEN_W'(i_window_length);
        end
        eob      = i_in.end_of_block;
        upd_high = (i_in.sample_high > r_win_high) ? i_in.sample_high : r_win_high;
        upd_low  = (i_in.sample_low < r_win_low) ? i_in.sample_low : r_win_low;
        fill_inc = {1'b0, r_fill} + (LEN_W+1)'(1);
        close    = (fill_inc >= {1'b0, len}) || eob;

        n_win_high = close ? '0 : upd_high;
        n_win_low  = close ? '0 : upd_low;
        n_fill     = close ? '0 : fill_inc[LEN_W-1:0];
    end

    // cascade: each level pairs the carried entry with its held partner
    always_comb begin
        em[0]    = close;
        carry[0] = close;
        cmax[0]  = scale_max(upd_high);
        cmin[0]  = scale_min(upd_low);
        for (int h = 0; h < NH; h++) begin
            n_held_max[h]   = r_held_max[h];
            n_held_min[h]   = r_held_min[h];
            n_held_valid[h] = r_held_valid[h];
            em[h+1]         = 1'b0;
            carry[h+1]      = 1'b0;
            cmax[h+1]       = cmax[h];
            cmin[h+1]       = cmin[h];
            if (carry[h] && r_held_valid[h]) begin
                cmax[h+1]       = peak_umax(r_held_max[h], cmax[h]);
                cmin[h+1]       = peak_umax(r_held_min[h], cmin[h]);
                n_held_valid[h] = 1'b0;
                em[h+1]         = 1'b1;
                carry[h+1]      = 1'b1;
            end else if (carry[h]) begin
                if (eob) begin
                    em[h+1]    = 1'b1;
                    carry[h+1] = 1'b1;
                end else begin
                    n_held_max[h]   = cmax[h];
                    n_held_min[h]   = cmin[h];
                    n_held_valid[h] = 1'b1;
                end
            end else if (r_held_valid[h] && eob) begin
                cmax[h+1]       = r_held_max[h];
                cmin[h+1]       = r_held_min[h];
                n_held_valid[h] = 1'b0;
                em[h+1]         = 1'b1;
                carry[h+1]      = 1'b1;
            end
            if (eob) begin
                n_held_valid[h] = 1'b0;
            end
        end
    end

    // positions wrap at LEVEL0_ENTRIES >> level (at least 1), clear at block end
    always_comb begin
        o_cnt = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            n_pos[l] = r_pos[l];
            if (eob) begin
                n_pos[l] = '0;
            end else if (em[l]) begin
                if (int'(r_pos[l]) + 1 >= (((LEVEL0_ENTRIES >> l) == 0) ?
                                           1 : (LEVEL0_ENTRIES >> l))) begin
                    n_pos[l] = '0;
                end else begin
                    n_pos[l] = r_pos[l] + PCNT_W'(1);
                end
            end
            o_ent[l].level    = LEVEL_W'(l);
            o_ent[l].position = POS_W'(r_pos[l]);
            o_ent[l].peak_max = cmax[l];
            o_ent[l].peak_min = cmin[l];
            o_cnt             = o_cnt + CNT_W'(em[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_high   <= '0;
            r_win_low    <= '0;
            r_fill       <= '0;
            r_held_valid <= '0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_pos[l] <= '0;
            end
        end else if (i_fire) begin
            r_win_high   <= n_win_high;
            r_win_low    <= n_win_low;
            r_fill       <= n_fill;
            r_held_valid <= n_held_valid;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_pos[l] <= n_pos[l];
            end
        end
    end

    // held peaks are only read behind their valid bit
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            for (int h = 0; h < NH; h++) begin
                r_held_max[h] <= n_held_max[h];
                r_held_min[h] <= n_held_min[h];
            end
        end
    end

    `PPB_ASSERT(a_eob_clears_held, i_clk, i_rst_n, (i_fire && i_in.end_of_block) |=> (r_held_valid == '0))

endmodule

// ===== rtl/ppb_out_buf.sv =====
// Result buffer: loads a whole result set at once, sends one beat per cycle
// while i_ready is high, lowest level first. Uses ppb_pkg, assert header.
`include "peak_pyramid_builder_top_assert.svh"

module ppb_out_buf import ppb_pkg::*; #(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF,
    parameter int CNT_W      = $clog2(NUM_LEVELS + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [CNT_W-1:0]        i_cnt,
    input  t_entry [NUM_LEVELS-1:0] i_ent,
    output logic                    o_free,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_out                    o_data
);

    localparam int IDX_W = $clog2(NUM_LEVELS);

    t_entry           r_ent [NUM_LEVELS];
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_rd,    n_rd;
    logic             r_valid, n_valid;

    logic             take;
    logic             last_beat;
    t_entry           cur;

    always_comb begin
        cur       = r_ent[r_rd];
        last_beat = (CNT_W'(r_rd) + CNT_W'(1)) == r_cnt;
        take      = r_valid && i_ready;
        o_free    = !r_valid || (take && last_beat);
        o_valid   = r_valid;

        o_data.level    = cur.level;
        o_data.position = cur.position;
        o_data.peak_max = cur.peak_max;
        o_data.peak_min = cur.peak_min;
        o_data.last     = last_beat;

        n_valid = r_valid;
        n_rd    = r_rd;
        if (i_load) begin
            n_valid = 1'b1;
            n_rd    = '0;
        end else if (take) begin
            if (last_beat) begin
                n_valid = 1'b0;
            end else begin
                n_rd = r_rd + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_rd    <= n_rd;
            if (i_load) begin
                r_cnt <= i_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_ent[l] <= i_ent[l];
            end
        end
    end

    `PPB_ASSERT(a_load_when_free, i_clk, i_rst_n, i_load |-> (o_free && (i_cnt != '0)))
    `PPB_ASSERT(a_rd_in_set, i_clk, i_rst_n, r_valid |-> (CNT_W'(r_rd) < r_cnt))
    `PPB_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule
